FILE: sv/slo_pkg.sv
// ----------------------------------------------------------------------------
// slo_pkg: shared types, constants and band tables
// Band edges, band reciprocals, sizes and the records passed between the
// front end, the band queue and the back end of the light organ.
// ----------------------------------------------------------------------------
package slo_pkg;

	// sizes
	localparam int BAND_COUNT = 28;
	localparam int BIN_COUNT  = 1024;
	localparam int LEVEL_MAX  = 255;
	localparam int DRIVE_BAND = 24;

	localparam int MAG_W   = 16;
	localparam int BIN_W   = 10;
	localparam int BAND_W  = 5;
	localparam int ACC_W   = 26;
	localparam int RECIP_W = 16;
	localparam int LEVEL_W = 9;
	localparam int DRV_W   = 8;
	localparam int REG_W   = 8;

	// level scaling: 433.5 = 867 / 2, squared
	localparam int SCALE_W  = 20;
	localparam logic [SCALE_W-1:0] SCALE_SQ = 20'd751689;
	localparam int PROD_W   = ACC_W + RECIP_W;      // 42
	localparam int HALF_W   = PROD_W / 2;           // 21
	localparam int PART_W   = HALF_W + SCALE_W;     // 41
	localparam int SUM_W    = PART_W + HALF_W;      // 62
	localparam int ROOT_SH  = 34;                   // 2 * 17
	localparam int RAD_W    = SUM_W - ROOT_SH;      // 28
	localparam int ROOT_W   = 9;
	localparam int ROOT_IW  = 4;
	localparam logic [ROOT_W-1:0] ROOT_CAP = ROOT_W'(LEVEL_MAX + 4);

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// band queue
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	// register map, index = byte address / 4
	typedef enum logic [1:0] {
		REG_COLOUR_THR = 2'd0,
		REG_LIGHT_THR  = 2'd1,
		REG_DECAY_STEP = 2'd2
	} slo_reg_t;

	// closed band handed from front to back
	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic [ACC_W-1:0]  sum;
	} slo_band_t;

	// configuration seen by the back end
	typedef struct packed {
		logic [REG_W-1:0] colour_thr;
		logic [REG_W-1:0] light_thr;
		logic [REG_W-1:0] decay_step;
	} slo_cfg_t;

	// one result record
	typedef struct packed {
		logic [BAND_W-1:0]  band_index;
		logic [LEVEL_W-1:0] band_level;
		logic [DRV_W-1:0]   red_level;
		logic [DRV_W-1:0]   green_level;
		logic [DRV_W-1:0]   blue_level;
		logic               drive_update;
	} slo_result_t;

	// last bin of each band
	function automatic logic [BIN_W-1:0] band_last_bin(input logic [BAND_W-1:0] band);
		logic [BIN_W-1:0] v;
		case (band)
			5'd0:  v = 10'd1;
			5'd1:  v = 10'd2;
			5'd2:  v = 10'd3;
			5'd3:  v = 10'd4;
			5'd4:  v = 10'd5;
			5'd5:  v = 10'd6;
			5'd6:  v = 10'd7;
			5'd7:  v = 10'd8;
			5'd8:  v = 10'd9;
			5'd9:  v = 10'd10;
			5'd10: v = 10'd13;
			5'd11: v = 10'd16;
			5'd12: v = 10'd21;
			5'd13: v = 10'd28;
			5'd14: v = 10'd36;
			5'd15: v = 10'd47;
			5'd16: v = 10'd60;
			5'd17: v = 10'd78;
			5'd18: v = 10'd101;
			5'd19: v = 10'd131;
			5'd20: v = 10'd169;
			5'd21: v = 10'd219;
			5'd22: v = 10'd283;
			5'd23: v = 10'd366;
			5'd24: v = 10'd474;
			5'd25: v = 10'd612;
			5'd26: v = 10'd792;
			5'd27: v = 10'd1023;
			default: v = '0;
		endcase
		return v;
	endfunction

	// round(65536 / log10(10 + band width)), Q0.16
	function automatic logic [RECIP_W-1:0] band_recip(input logic [BAND_W-1:0] band);
		logic [RECIP_W-1:0] v;
		case (band)
			5'd0, 5'd1, 5'd2, 5'd3, 5'd4,
			5'd5, 5'd6, 5'd7, 5'd8, 5'd9: v = 16'd62931;
			5'd10, 5'd11: v = 16'd58832;
			5'd12: v = 16'd55724;
			5'd13: v = 16'd53262;
			5'd14: v = 16'd52209;
			5'd15: v = 16'd49565;
			5'd16: v = 16'd48127;
			5'd17: v = 16'd45286;
			5'd18: v = 16'd43158;
			5'd19: v = 16'd40907;
			5'd20: v = 16'd38981;
			5'd21: v = 16'd36856;
			5'd22: v = 16'd35060;
			5'd23: v = 16'd33293;
			5'd24: v = 16'd31631;
			5'd25: v = 16'd30197;
			5'd26: v = 16'd28760;
			5'd27: v = 16'd27513;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/slo_front.sv
// ----------------------------------------------------------------------------
// slo_front: bin intake and band accumulation
// Counts bins of a frame, sums them into the current band and hands each
// closed band with its sum to the band queue.
// ----------------------------------------------------------------------------
module slo_front import slo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [MAG_W-1:0] in_mag,
	input  logic             in_last,
	input  logic             q_full,
	output logic             push,
	output slo_band_t        push_data
);

	logic [BIN_W-1:0]  bin_q;
	logic [BAND_W-1:0] band_q;
	logic [ACC_W-1:0]  acc_q;

	logic [ACC_W:0]    acc_sum;
	logic [ACC_W-1:0]  acc_sat;
	logic              active;
	logic              close;
	logic              frame_end;
	logic              accept;

	// saturating add and band close detect
	always_comb begin
		acc_sum   = {1'b0, acc_q} + (ACC_W+1)'(in_mag);
		acc_sat   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
		active    = (bin_q != '0) && (band_q < BAND_W'(BAND_COUNT));
		close     = active && (bin_q == band_last_bin(band_q));
		frame_end = in_last || (bin_q == BIN_W'(BIN_COUNT - 1));
	end

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign push      = accept && close;
	assign push_data = '{band: band_q, sum: acc_sat};

	// counters and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			band_q <= '0;
			acc_q  <= '0;
		end else if (accept) begin
			if (frame_end) begin
				bin_q  <= '0;
				band_q <= '0;
				acc_q  <= '0;
			end else begin
				bin_q <= bin_q + 1'b1;
				if (close) begin
					acc_q  <= '0;
					band_q <= (band_q == BAND_W'(BAND_COUNT - 1)) ? '0 : band_q + 1'b1;
				end else if (active) begin
					acc_q <= acc_sat;
				end
			end
		end
	end

endmodule

FILE: sv/slo_queue.sv
// ----------------------------------------------------------------------------
// slo_queue: closed band queue
// Short FIFO of closed bands between the front end and the back end.
// ----------------------------------------------------------------------------
module slo_queue import slo_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  slo_band_t push_data,
	input  logic      pop,
	output slo_band_t head,
	output logic      empty,
	output logic      full
);

	slo_band_t          entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: sv/slo_back.sv
// ----------------------------------------------------------------------------
// slo_back: band level and light drive
// Scales each closed band sum to a level with a split multiply and a
// bit-serial root, updates colour and light state and holds the result.
// ----------------------------------------------------------------------------
module slo_back import slo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  slo_cfg_t    cfg,
	input  logic        q_empty,
	input  slo_band_t   q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output slo_result_t out_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SPLIT,
		ST_SUM,
		ST_ROOT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		COLOUR_RED   = 2'd0,
		COLOUR_GREEN = 2'd1,
		COLOUR_BLUE  = 2'd2
	} colour_t;

	state_t             state_q;
	slo_band_t          item_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PART_W-1:0]  hi_q;
	logic [PART_W-1:0]  lo_q;
	logic [RAD_W-1:0]   rad_q;
	logic [ROOT_W-1:0]  root_q;
	logic [ROOT_IW-1:0] bit_q;
	logic [1:0]         colour_q;
	logic [DRV_W-1:0]   light_q;
	logic               out_valid_q;
	slo_result_t        out_q;

	logic [SUM_W-1:0]     scaled;
	logic [ROOT_W-1:0]    cand;
	logic [2*ROOT_W-1:0]  cand_sq;
	logic [LEVEL_W-1:0]   level;
	logic                 over_colour;
	logic                 over_light;
	logic [DRV_W-1:0]     light_next;
	logic [1:0]           colour_next;
	logic                 is_drive;
	logic                 out_free;
	slo_result_t          res;

	// scaled product and one root trial
	always_comb begin
		scaled  = {hi_q, HALF_W'(0)} + {HALF_W'(0), lo_q};
		cand    = root_q | (ROOT_W'(1) << bit_q);
		cand_sq = cand * cand;
	end

	// level, colour and light for the finished band
	always_comb begin
		level       = (root_q > ROOT_CAP) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(root_q - ROOT_W'(4));
		over_colour = $signed(level) > $signed({1'b0, cfg.colour_thr});
		over_light  = $signed(level) > $signed({1'b0, cfg.light_thr});
		is_drive    = (item_q.band == BAND_W'(DRIVE_BAND));

		colour_next = colour_q;
		if (item_q.band == '0 && over_colour) begin
			case (colour_q)
				COLOUR_RED:   colour_next = COLOUR_GREEN;
				COLOUR_GREEN: colour_next = COLOUR_BLUE;
				default:      colour_next = COLOUR_RED;
			endcase
		end

		light_next = light_q;
		if (is_drive) begin
			if (over_light) begin
				light_next = level[DRV_W-1:0];
			end else begin
				light_next = (light_q > cfg.decay_step) ? light_q - cfg.decay_step : '0;
			end
		end

		res              = '0;
		res.band_index   = item_q.band;
		res.band_level   = level;
		res.drive_update = is_drive;
		if (is_drive) begin
			case (colour_q)
				COLOUR_RED:   res.red_level   = light_next;
				COLOUR_GREEN: res.green_level = light_next;
				default:      res.blue_level  = light_next;
			endcase
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			colour_q    <= COLOUR_RED;
			light_q     <= '0;
			out_valid_q <= 1'b0;
			item_q      <= '0;
			prod_q      <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			rad_q       <= '0;
			root_q      <= '0;
			bit_q       <= '0;
			out_q       <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						item_q  <= q_head;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= item_q.sum * band_recip(item_q.band);
					state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					hi_q    <= prod_q[PROD_W-1:HALF_W] * SCALE_SQ;
					lo_q    <= prod_q[HALF_W-1:0] * SCALE_SQ;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					rad_q   <= scaled[SUM_W-1:ROOT_SH];
					root_q  <= '0;
					bit_q   <= ROOT_IW'(ROOT_W - 1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (RAD_W'(cand_sq) <= rad_q) begin
						root_q <= cand;
					end
					if (bit_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q    <= res;
						colour_q <= colour_next;
						light_q  <= light_next;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/spectrum_band_light_organ.sv
// ----------------------------------------------------------------------------
// spectrum_band_light_organ: log band spectrum analyzer and light organ
// Sums FFT bins into 28 log-spaced bands, emits a scaled level per band and
// drives a red/green/blue light from band 0 and the drive band.
//
//   channel   dir  handshake               payload
//   s_*       in   s_tvalid / s_tready     s_tdata bin_magnitude, s_tlast last_bin
//   m_*       out  m_tvalid / m_tready     m_tdata band fields, m_tuser drive_update
//   APB       in   psel&penable&pwrite     paddr 4*index, pwdata, prdata
//
// The front end takes one bin per cycle while the band queue has room.
// Each closed band takes the back end through queue pop, multiply, split
// multiply, sum, nine root steps and output load, one band at a time, so a
// run of one-bin bands stalls the input once the four-entry queue has filled.
// Reset clears counters, colour (red), light level and the registers to
// their defaults; a stalled m_tready holds the result and the back end.
// ----------------------------------------------------------------------------
module spectrum_band_light_organ import slo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] bin_magnitude
	input  logic        s_tlast,   // last_bin
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [4:0] band_index, [13:5] band_level, [21:14] red_level,
	                               // [29:22] green_level, [37:30] blue_level, [39:38] zero
	output logic        m_tuser,   // drive_update
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	slo_cfg_t    cfg_q;
	logic        q_full;
	logic        q_empty;
	logic        push;
	logic        pop;
	slo_band_t   push_data;
	slo_band_t   q_head;
	slo_result_t res;
	logic        wr_en;
	slo_reg_t    reg_idx;

	// configuration registers
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = slo_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.colour_thr <= REG_W'(50);
			cfg_q.light_thr  <= REG_W'(150);
			cfg_q.decay_step <= REG_W'(10);
		end else if (wr_en) begin
			case (reg_idx)
				REG_COLOUR_THR: cfg_q.colour_thr <= pwdata[REG_W-1:0];
				REG_LIGHT_THR:  cfg_q.light_thr  <= pwdata[REG_W-1:0];
				REG_DECAY_STEP: cfg_q.decay_step <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_COLOUR_THR: prdata = 32'(cfg_q.colour_thr);
			REG_LIGHT_THR:  prdata = 32'(cfg_q.light_thr);
			REG_DECAY_STEP: prdata = 32'(cfg_q.decay_step);
			default:        prdata = '0;
		endcase
	end

	slo_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mag    (s_tdata),
		.in_last   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	slo_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	slo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	// result packing
	assign m_tdata = {2'b00, res.blue_level, res.green_level, res.red_level,
		res.band_level, res.band_index};
	assign m_tuser = res.drive_update;

	// drive results come only from the drive band
	a_drive_band: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> res.band_index == BAND_W'(DRIVE_BAND))
		else $error("drive update on a band other than the drive band");

	// colour levels are zero outside drive results
	a_no_colour: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[37:14] == '0)
		else $error("colour level set on a non-drive result");

	// at most one colour lit
	a_one_colour: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones({res.red_level != '0, res.green_level != '0,
			res.blue_level != '0}) <= 1)
		else $error("more than one colour lit");

	// level never below -4
	a_level_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(res.band_level) >= $signed(LEVEL_W'(-4)))
		else $error("band level below floor");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking regression for spectrum_band_light_organ
// Streams FFT bin frames into the block: a directed table first, then random
// frames of mixed length and loudness under several register settings.
// Every band result is checked field by field against a bit-true band
// accumulator and level/colour/light model here or a typed table row.
// ----------------------------------------------------------------------------
module tb;
	import slo_pkg::*;

	localparam int QUIET_LIMIT = 3000;   // cycles with no transaction at all
	localparam int HOLD_CYCLES = 400;    // one long result back-pressure stretch
	localparam int SETTLE      = 30;     // cycles after the last result
	localparam longint unsigned ROOT_SCALE = 64'd751689;   // 867 squared
	localparam logic [25:0] SUM_TOP = 26'h3FF_FFFF;
	localparam logic [8:0] LEVEL_FLOOR = -9'sd4;
	localparam logic [8:0] LEVEL_TOP   = 9'd255;
	localparam int COLOUR_RED   = 0;
	localparam int COLOUR_GREEN = 1;
	localparam int COLOUR_BLUE  = 2;

	typedef struct {
		logic [15:0] mag;
		logic        last;
		bit          typed;     // expectation given in the row
		bit          has_res;
		logic [4:0]  band;
		logic [8:0]  level;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] bin_magnitude
	logic        s_tlast;   // last_bin
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [4:0] band_index, [13:5] band_level, [21:14] red_level,
	                        // [29:22] green_level, [37:30] blue_level, [39:38] zero
	logic        m_tuser;   // drive_update
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// last bin and Q0.16 reciprocal of each band
	bit [9:0] band_end_bin [28] = '{
		1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 13, 16, 21, 28, 36, 47, 60, 78,
		101, 131, 169, 219, 283, 366, 474, 612, 792, 1023
	};
	bit [15:0] band_recip [28] = '{
		62931, 62931, 62931, 62931, 62931, 62931, 62931, 62931, 62931, 62931,
		58832, 58832, 55724, 53262, 52209, 49565, 48127, 45286, 43158, 40907,
		38981, 36856, 35060, 33293, 31631, 30197, 28760, 27513
	};

	// directed frames, starting from reset state and default thresholds
	stim_row_t dir_rows [15] = '{
		'{16'hFFFF, 1'b0, 1'b1, 1'b0, 5'd0, 9'd0},          // bin 0 is skipped
		'{16'h0000, 1'b0, 1'b1, 1'b1, 5'd0, LEVEL_FLOOR},   // silent band
		'{16'hFFFF, 1'b0, 1'b1, 1'b1, 5'd1, LEVEL_TOP},     // full scale, capped
		'{16'h0001, 1'b1, 1'b0, 1'b0, 5'd0, 9'd0},          // early frame end
		'{16'hFFFF, 1'b1, 1'b1, 1'b0, 5'd0, 9'd0},          // frame end on bin 0
		'{16'h0000, 1'b0, 1'b1, 1'b0, 5'd0, 9'd0},
		'{16'hFFFF, 1'b0, 1'b1, 1'b1, 5'd0, LEVEL_TOP},     // colour advances
		'{16'h8000, 1'b0, 1'b0, 1'b0, 5'd0, 9'd0},
		'{16'hFFFF, 1'b0, 1'b1, 1'b1, 5'd2, LEVEL_TOP},
		'{16'h0000, 1'b0, 1'b1, 1'b1, 5'd3, LEVEL_FLOOR},
		'{16'h3039, 1'b1, 1'b0, 1'b0, 5'd0, 9'd0},
		'{16'h0000, 1'b0, 1'b1, 1'b0, 5'd0, 9'd0},
		'{16'h00FF, 1'b0, 1'b0, 1'b0, 5'd0, 9'd0},          // quiet, no advance
		'{16'hFFFF, 1'b0, 1'b1, 1'b1, 5'd1, LEVEL_TOP},
		'{16'h0000, 1'b1, 1'b1, 1'b1, 5'd2, LEVEL_FLOOR}
	};

	// model state and register copies
	logic [9:0]  org_bin;
	logic [4:0]  org_band;
	logic [25:0] org_sum;
	int          org_colour;
	int          org_light;
	int          thr_colour;
	int          thr_light;
	int          step_decay;

	slo_result_t band_results_due [$];
	int          n_predicted;
	int          mismatches;
	int          n_results;
	int          items_sent;
	int          quiet_cycles;
	bit          idle_on;
	bit          pressure_done;

	spectrum_band_light_organ dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #6 clk = ~clk;

	// floor(sqrt(sum * recip / 2^32) * 433.5) - 4, capped at the top level
	function automatic int band_level_of(input logic [25:0] sum, input logic [15:0] recip);
		longint unsigned rad;
		longint unsigned root;
		longint unsigned cand;
		int whole;
		rad = sum;
		rad = rad * recip;
		rad = rad * ROOT_SCALE;
		root = 0;
		for (int i = 30; i >= 0; i--) begin
			cand = root | (64'd1 << i);
			if (cand * cand <= rad)
				root = cand;
		end
		whole = int'(root >> 17);
		if (whole > LEVEL_MAX + 4)
			return LEVEL_MAX;
		return whole - 4;
	endfunction

	// one accepted bin: accumulate, close the band, update colour and light
	function automatic void accumulate_bin(input logic [15:0] mag, input logic last);
		logic [26:0] sum_next;
		int lvl;
		slo_result_t r;
		if (org_bin != 0 && org_band < BAND_COUNT) begin
			sum_next = {1'b0, org_sum} + mag;
			org_sum = (sum_next > SUM_TOP) ? SUM_TOP : sum_next[25:0];
			if (org_bin == band_end_bin[org_band]) begin
				lvl = band_level_of(org_sum, band_recip[org_band]);
				r = '0;
				r.band_index = org_band;
				r.band_level = 9'(lvl);
				if (org_band == 0 && lvl > thr_colour)
					org_colour = (org_colour >= COLOUR_BLUE) ? COLOUR_RED : org_colour + 1;
				if (org_band == DRIVE_BAND) begin
					if (lvl > thr_light)
						org_light = (lvl > 255) ? 255 : lvl;
					else
						org_light = (org_light > step_decay) ? org_light - step_decay : 0;
					r.drive_update = 1'b1;
					if (org_colour == COLOUR_RED)
						r.red_level = 8'(org_light);
					else if (org_colour == COLOUR_GREEN)
						r.green_level = 8'(org_light);
					else
						r.blue_level = 8'(org_light);
				end
				band_results_due.push_back(r);
				n_predicted++;
				org_sum = '0;
				org_band = org_band + 5'd1;
				if (org_band >= BAND_COUNT)
					org_band = '0;
			end
		end
		if (last || int'(org_bin) + 1 >= BIN_COUNT) begin
			org_bin = '0;
			org_band = '0;
			org_sum = '0;
		end else begin
			org_bin = org_bin + 10'd1;
		end
	endfunction

	// APB write: setup, access, then idle
	task automatic reg_write(input slo_reg_t idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_COLOUR_THR: thr_colour = val;
			REG_LIGHT_THR:  thr_light = val;
			default:        step_decay = val;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// APB read and compare with the given value
	task automatic reg_check(input slo_reg_t idx, input int val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(val)) begin
			$error("prdata[%s]: expected %0d, got %0d", idx.name(), val, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_thresholds(input int c, input int l, input int d);
		reg_write(REG_COLOUR_THR, 8'(c));
		reg_write(REG_LIGHT_THR, 8'(l));
		reg_write(REG_DECAY_STEP, 8'(d));
		reg_check(REG_COLOUR_THR, c);
		reg_check(REG_LIGHT_THR, l);
		reg_check(REG_DECAY_STEP, d);
	endtask

	// wait for every due result, then let the back end settle
	task automatic drain();
		while (band_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// offer one bin, with an optional idle burst ahead of it
	task automatic send_bin(input logic [15:0] mag, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= mag;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		accumulate_bin(mag, last);
		items_sent++;
	endtask

	// one frame of random loudness; close marks its final bin as last
	task automatic send_frame(input int len, input bit close);
		int cap;
		int pick;
		logic [15:0] mag;
		case ($urandom_range(0, 4))
			0: cap = 0;
			1: cap = 15;
			2: cap = 255;
			3: cap = 4095;
			default: cap = 65535;
		endcase
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 15);
			if (pick == 0)
				mag = 16'hFFFF;
			else if (pick == 1)
				mag = 16'h0000;
			else
				mag = 16'($urandom_range(0, cap));
			send_bin(mag, close && i == len - 1);
		end
	endtask

	// mostly closed frames: short ones close low bands, medium ones reach wider bands
	task automatic run_phase(input int budget);
		int start;
		int kind;
		start = items_sent;
		while (items_sent - start < budget) begin
			kind = $urandom_range(0, 19);
			if (kind < 12)
				send_frame($urandom_range(1, 40), 1'b1);
			else if (kind < 18)
				send_frame($urandom_range(41, 120), 1'b1);
			else
				send_frame($urandom_range(1, 60), 1'b0);
		end
	endtask

	// result check against the oldest due band
	always @(posedge clk) begin : result_check
		slo_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (band_results_due.size() == 0) begin
				$error("unexpected band result: band_index %0d", m_tdata[4:0]);
				mismatches++;
			end else begin
				want = band_results_due.pop_front();
				if (m_tdata[4:0] !== want.band_index) begin
					$error("band_index: expected %0d, got %0d", want.band_index, m_tdata[4:0]);
					mismatches++;
				end
				if (m_tdata[13:5] !== want.band_level) begin
					$error("band_level: expected %0d, got %0d",
						$signed(want.band_level), $signed(m_tdata[13:5]));
					mismatches++;
				end
				if (m_tdata[21:14] !== want.red_level) begin
					$error("red_level: expected %0d, got %0d", want.red_level, m_tdata[21:14]);
					mismatches++;
				end
				if (m_tdata[29:22] !== want.green_level) begin
					$error("green_level: expected %0d, got %0d",
						want.green_level, m_tdata[29:22]);
					mismatches++;
				end
				if (m_tdata[37:30] !== want.blue_level) begin
					$error("blue_level: expected %0d, got %0d", want.blue_level, m_tdata[37:30]);
					mismatches++;
				end
				if (m_tuser !== want.drive_update) begin
					$error("drive_update: expected %0d, got %0d", want.drive_update, m_tuser);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("spectrum_band_light_organ regression: fail");
			$finish;
		end
	end

	// result side: random stall bursts and one long hold once results flow
	initial begin
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!pressure_done && n_results >= 40) begin
				pressure_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int n_before;
		slo_result_t typed_res;
		mismatches = 0;
		n_results = 0;
		n_predicted = 0;
		items_sent = 0;
		quiet_cycles = 0;
		idle_on = 1'b0;
		pressure_done = 1'b0;
		org_bin = '0;
		org_band = '0;
		org_sum = '0;
		org_colour = COLOUR_RED;
		org_light = 0;
		thr_colour = 50;
		thr_light = 150;
		step_decay = 10;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the registers
		reg_check(REG_COLOUR_THR, 50);
		reg_check(REG_LIGHT_THR, 150);
		reg_check(REG_DECAY_STEP, 10);

		// directed table
		idle_on = 1'b1;
		foreach (dir_rows[i]) begin
			n_before = n_predicted;
			send_bin(dir_rows[i].mag, dir_rows[i].last);
			if (dir_rows[i].typed) begin
				repeat (n_predicted - n_before)
					void'(band_results_due.pop_back());
				if (dir_rows[i].has_res) begin
					typed_res = '0;
					typed_res.band_index = dir_rows[i].band;
					typed_res.band_level = dir_rows[i].level;
					band_results_due.push_back(typed_res);
				end
			end
		end
		s_tvalid <= 1'b0;

		// random phases under several threshold settings
		for (int p = 0; p < 6; p++) begin
			drain();
			if (p == 1)
				set_thresholds(0, 0, 0);
			else if (p == 2)
				set_thresholds(255, 255, 255);
			else
				set_thresholds($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
			// missing frame end: run past the bin count before the final bin is marked last
			if (p == 0)
				send_frame(BIN_COUNT + 30, 1'b1);
			run_phase(25);
			s_tvalid <= 1'b0;
		end

		// last part without idling on either side
		drain();
		set_thresholds($urandom_range(0, 120), $urandom_range(0, 200), $urandom_range(1, 60));
		idle_on = 1'b0;
		run_phase(20);
		while (items_sent < 1450)
			send_frame($urandom_range(1, 40), 1'b1);
		s_tvalid <= 1'b0;
		drain();

		if (mismatches == 0 && band_results_due.size() == 0)
			$display("spectrum_band_light_organ regression: pass");
		else
			$display("spectrum_band_light_organ regression: fail");
		$finish;
	end

endmodule
